@@ sv/lavm_pkg.sv @@
// Shared constants, types and helpers for the look-at view matrix pipeline.
package lavm_pkg;

  localparam int COORD_W   = 32;              // Q16.16 input coordinates
  localparam int UNIT_W    = 32;              // Q2.30 basis components
  localparam int SHIFT_W   = 34;              // Q18.16 translation terms
  localparam int FRAC_W    = 30;              // fraction bits of Q2.30
  localparam int DIR_W     = COORD_W + 1;     // aim minus position
  localparam int CROSS_W   = 2 * COORD_W;     // exact cross and dot products
  localparam int SCALE_W   = 30;              // scaled magnitude, msb at bit 29
  localparam int SQR_W     = 2 * SCALE_W;
  localparam int ROOT_W    = 64;              // isqrt working width
  localparam int SQ_STEPS  = 32;              // one result bit per stage
  localparam int QUO_W     = 31;              // quotient bits, q <= 2^30
  localparam int DIV_STEPS = QUO_W;
  localparam int REM_W     = SCALE_W + FRAC_W + 2;

  // mag, msb search, shift, square, sum, root, divider setup, divide, output
  localparam int UNIT_LAT  = 4 + 1 + SQ_STEPS + 1 + DIV_STEPS + 1;
  localparam int IN_LAT    = 1;
  localparam int CROSS_LAT = 2;
  localparam int VEC_LAT   = 3;
  localparam int DOT_LAT   = 3;
  localparam int PIPE_LAT  = IN_LAT + UNIT_LAT + CROSS_LAT + UNIT_LAT + VEC_LAT + DOT_LAT;

  localparam int IN_DATA_W  = 9 * COORD_W;
  localparam int OUT_DATA_W = 392;
  localparam int VEC3_W     = 3 * COORD_W;

  typedef logic signed [COORD_W-1:0] word_t;
  typedef logic signed [CROSS_W-1:0] wide_t;

  // Side data that rides along the normalizer's root and divide stages.
  typedef struct packed {
    logic [2:0][SCALE_W-1:0] sc;
    logic [2:0]              neg;
    logic                    zero;
  } lavm_side_t;

  function automatic wide_t smul(input word_t a, input word_t b);
    return CROSS_W'(a) * CROSS_W'(b);
  endfunction

endpackage

@@ sv/lavm_delay.sv @@
// Enabled shift line that carries side data alongside the pipeline.
module lavm_delay
  import lavm_pkg::*;
#(
  parameter int WIDTH = COORD_W,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  assign q_o = line_q[DEPTH-1];

endmodule

@@ sv/lavm_unitize.sv @@
// Pipelined vector normalizer: scale, bit-per-stage isqrt, bit-per-stage divide.
module lavm_unitize
  import lavm_pkg::*;
#(
  parameter int W = DIR_W
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [W-1:0]      vec_i  [3],
  output logic signed [UNIT_W-1:0] unit_o [3]
);

  localparam int AW      = $clog2(W);
  localparam int TOP_BIT = SCALE_W - 1;

  // stage 1: magnitudes and largest magnitude
  logic [W-1:0] mag_d [3];
  logic [W-1:0] max_d;
  logic [W-1:0] mag1_q [3];
  logic [W-1:0] max1_q;
  logic [2:0]   neg1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][W-1] ? W'(-vec_i[i]) : W'(vec_i[i]);
    end
    max_d = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
    if (mag_d[2] > max_d) begin
      max_d = mag_d[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= mag_d[i];
        neg1_q[i] <= vec_i[i][W-1];
      end
      max1_q <= max_d;
    end
  end

  // stage 2: msb position, shift direction and amount
  logic [AW-1:0] msb_d;
  logic [W-1:0]  mag2_q [3];
  logic [2:0]    neg2_q;
  logic          zero2_q;
  logic          right2_q;
  logic [AW-1:0] amt2_q;

  always_comb begin
    msb_d = '0;
    for (int b = 0; b < W; b++) begin
      if (max1_q[b]) msb_d = AW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q   <= mag1_q;
      neg2_q   <= neg1_q;
      zero2_q  <= (max1_q == '0);
      right2_q <= (msb_d >= AW'(TOP_BIT));
      amt2_q   <= (msb_d >= AW'(TOP_BIT)) ? msb_d - AW'(TOP_BIT) : AW'(TOP_BIT) - msb_d;
    end
  end

  // stage 3: scale so the largest lands in [2^29, 2^30); right shift truncates
  lavm_side_t side3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        side3_q.sc[i] <= right2_q ? SCALE_W'(mag2_q[i] >> amt2_q)
                                  : SCALE_W'(mag2_q[i] << amt2_q);
      end
      side3_q.neg  <= neg2_q;
      side3_q.zero <= zero2_q;
    end
  end

  // stage 4: squares
  logic [SQR_W-1:0] sqr4_q [3];
  lavm_side_t       side4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sqr4_q[i] <= SQR_W'(side3_q.sc[i]) * SQR_W'(side3_q.sc[i]);
      end
      side4_q <= side3_q;
    end
  end

  // root entry: sum of squares, then one root bit per stage
  logic [ROOT_W-1:0] sn_q [SQ_STEPS+1];
  logic [ROOT_W-1:0] sr_q [SQ_STEPS+1];
  lavm_side_t        sq_side_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q[0]      <= ROOT_W'(sqr4_q[0]) + ROOT_W'(sqr4_q[1]) + ROOT_W'(sqr4_q[2]);
      sr_q[0]      <= '0;
      sq_side_q[0] <= side4_q;
    end
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_root
    localparam logic [ROOT_W-1:0] BitK = ROOT_W'(1) << (ROOT_W - 2 * k);
    logic [ROOT_W-1:0] trial;
    logic [ROOT_W-1:0] n_d;
    logic [ROOT_W-1:0] r_d;

    always_comb begin
      trial = sr_q[k-1] + BitK;
      if (sn_q[k-1] >= trial) begin
        n_d = sn_q[k-1] - trial;
        r_d = (sr_q[k-1] >> 1) + BitK;
      end else begin
        n_d = sn_q[k-1];
        r_d = sr_q[k-1] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sn_q[k]      <= n_d;
        sr_q[k]      <= r_d;
        sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  // divider setup: (c << 30) + s/2 over s
  logic [REM_W-1:0] dv_rem_q [DIV_STEPS+1][3];
  logic [QUO_W-1:0] dv_quo_q [DIV_STEPS+1][3];
  logic [31:0]      dv_den_q [DIV_STEPS+1];
  lavm_side_t       dv_side_q [DIV_STEPS+1];
  logic [31:0]      root;

  assign root = sr_q[SQ_STEPS][31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= REM_W'({sq_side_q[SQ_STEPS].sc[i], {FRAC_W{1'b0}}})
                        + REM_W'(root >> 1);
        dv_quo_q[0][i] <= '0;
      end
      dv_den_q[0]  <= root;
      dv_side_q[0] <= sq_side_q[SQ_STEPS];
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - j;
    logic [REM_W-1:0] trial;

    assign trial = REM_W'(dv_den_q[j-1]) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_q[j-1][i] >= trial) begin
            dv_rem_q[j][i] <= dv_rem_q[j-1][i] - trial;
            dv_quo_q[j][i] <= dv_quo_q[j-1][i] | (QUO_W'(1) << B);
          end else begin
            dv_rem_q[j][i] <= dv_rem_q[j-1][i];
            dv_quo_q[j][i] <= dv_quo_q[j-1][i];
          end
        end
        dv_den_q[j]  <= dv_den_q[j-1];
        dv_side_q[j] <= dv_side_q[j-1];
      end
    end
  end

  // output: sign back on, zero vector gives zero
  logic signed [UNIT_W-1:0] unit_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_side_q[DIV_STEPS].zero) begin
          unit_q[i] <= '0;
        end else if (dv_side_q[DIV_STEPS].neg[i]) begin
          unit_q[i] <= -$signed(UNIT_W'(dv_quo_q[DIV_STEPS][i]));
        end else begin
          unit_q[i] <= $signed(UNIT_W'(dv_quo_q[DIV_STEPS][i]));
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule

@@ sv/look_at_view_matrix.sv @@
// Top level: look-at view matrix, fully pipelined, one transfer per cycle unless the output stalls.
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tdata: pos, aim, up; tuser: aim_is_target
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata: u, v, w, shift_u/v/w
//
// One item enters per cycle unless the output stalls. Most of the pipeline
// sits in the two normalizers: 32 isqrt stages and 31 divide stages each.
// Reset clears only the valid line; payload registers are not reset.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall holds every stage and loses nothing.
module look_at_view_matrix
  import lavm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, up_x, up_y, up_z (32 bits each)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // aim_is_target
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // right_x..z, cam_up_x..z, forward_x..z (32 each), shift_u/v/w (34 each), pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic en;
  logic [PIPE_LAT-1:0] vld_q;

  // global advance: output empty or being taken
  assign en            = !vld_q[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  // input stage: unpack, form direction
  word_t in_pos [3];
  word_t in_aim [3];
  word_t in_up  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pos[i] = $signed(s_axis_tdata[COORD_W*i +: COORD_W]);
      in_aim[i] = $signed(s_axis_tdata[COORD_W*(3+i) +: COORD_W]);
      in_up[i]  = $signed(s_axis_tdata[COORD_W*(6+i) +: COORD_W]);
    end
  end

  logic signed [DIR_W-1:0] dir_q [3];
  logic [VEC3_W-1:0]       pos_a_q;
  logic [VEC3_W-1:0]       up_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= s_axis_tuser ? DIR_W'(in_aim[i]) - DIR_W'(in_pos[i]) : DIR_W'(in_aim[i]);
      end
      pos_a_q <= s_axis_tdata[VEC3_W-1:0];
      up_a_q  <= s_axis_tdata[3*VEC3_W-1:2*VEC3_W];
    end
  end

  // forward vector w
  word_t w_s [3];

  lavm_unitize #(.W(DIR_W)) u_unit_w (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (dir_q),
    .unit_o (w_s)
  );

  logic [VEC3_W-1:0] up_w_flat;
  word_t             up_w [3];

  lavm_delay #(.WIDTH(VEC3_W), .DEPTH(UNIT_LAT)) u_dly_up (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (up_a_q),
    .q_o   (up_w_flat)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_w[i] = $signed(up_w_flat[COORD_W*i +: COORD_W]);
    end
  end

  // w x up, exact
  wide_t xp_q [6];
  wide_t x_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q[0] <= smul(w_s[1], up_w[2]);
      xp_q[1] <= smul(up_w[1], w_s[2]);
      xp_q[2] <= smul(w_s[2], up_w[0]);
      xp_q[3] <= smul(up_w[2], w_s[0]);
      xp_q[4] <= smul(w_s[0], up_w[1]);
      xp_q[5] <= smul(up_w[0], w_s[1]);
      x_q[0]  <= xp_q[0] - xp_q[1];
      x_q[1]  <= xp_q[2] - xp_q[3];
      x_q[2]  <= xp_q[4] - xp_q[5];
    end
  end

  // right vector u
  word_t u_s [3];

  lavm_unitize #(.W(CROSS_W)) u_unit_u (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (x_q),
    .unit_o (u_s)
  );

  logic [VEC3_W-1:0] w_u_flat;
  word_t             w_u [3];

  lavm_delay #(.WIDTH(VEC3_W), .DEPTH(CROSS_LAT + UNIT_LAT)) u_dly_w (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({w_s[2], w_s[1], w_s[0]}),
    .q_o   (w_u_flat)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_u[i] = $signed(w_u_flat[COORD_W*i +: COORD_W]);
    end
  end

  // camera up v = w x u, rounded to Q2.30 and saturated
  wide_t vp_q [6];
  wide_t vd_q [3];
  word_t v_q  [3];
  logic [CROSS_W-1:0] vmag [3];
  logic [SHIFT_W-1:0] vrnd [3];
  word_t              v_d  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i] = vd_q[i][CROSS_W-1] ? CROSS_W'(-vd_q[i]) : CROSS_W'(vd_q[i]);
      vrnd[i] = SHIFT_W'((vmag[i] + (CROSS_W'(1) << (FRAC_W - 1))) >> FRAC_W);
      if (vd_q[i][CROSS_W-1]) begin
        v_d[i] = (vrnd[i] > (SHIFT_W'(1) << (UNIT_W - 1))) ? {1'b1, {(UNIT_W-1){1'b0}}}
                                                           : -$signed(vrnd[i][UNIT_W-1:0]);
      end else begin
        v_d[i] = (vrnd[i] > SHIFT_W'({1'b0, {(UNIT_W-1){1'b1}}})) ?
                 {1'b0, {(UNIT_W-1){1'b1}}} : $signed(vrnd[i][UNIT_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vp_q[0] <= smul(w_u[1], u_s[2]);
      vp_q[1] <= smul(u_s[1], w_u[2]);
      vp_q[2] <= smul(w_u[2], u_s[0]);
      vp_q[3] <= smul(u_s[2], w_u[0]);
      vp_q[4] <= smul(w_u[0], u_s[1]);
      vp_q[5] <= smul(u_s[0], w_u[1]);
      vd_q[0] <= vp_q[0] - vp_q[1];
      vd_q[1] <= vp_q[2] - vp_q[3];
      vd_q[2] <= vp_q[4] - vp_q[5];
      v_q     <= v_d;
    end
  end

  // align u, w and position with v
  logic [VEC3_W-1:0] u_v_flat;
  logic [VEC3_W-1:0] w_v_flat;
  logic [VEC3_W-1:0] pos_v_flat;

  lavm_delay #(.WIDTH(VEC3_W), .DEPTH(VEC_LAT)) u_dly_u (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({u_s[2], u_s[1], u_s[0]}),
    .q_o   (u_v_flat)
  );

  lavm_delay #(.WIDTH(VEC3_W), .DEPTH(VEC_LAT)) u_dly_w2 (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (w_u_flat),
    .q_o   (w_v_flat)
  );

  lavm_delay #(.WIDTH(VEC3_W), .DEPTH(UNIT_LAT + CROSS_LAT + UNIT_LAT + VEC_LAT)) u_dly_pos (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (pos_a_q),
    .q_o   (pos_v_flat)
  );

  // basis rows at dot-product input: row 0 u, row 1 v, row 2 w
  word_t basis [3][3];
  word_t pos_v [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      basis[0][i] = $signed(u_v_flat[COORD_W*i +: COORD_W]);
      basis[1][i] = v_q[i];
      basis[2][i] = $signed(w_v_flat[COORD_W*i +: COORD_W]);
      pos_v[i]    = $signed(pos_v_flat[COORD_W*i +: COORD_W]);
    end
  end

  // translations: -round(dot / 2^30), halves up, saturated to 34 bits
  localparam wide_t RndHalf = wide_t'(1) <<< (FRAC_W - 1);
  localparam wide_t ShMax   = (wide_t'(1) <<< (SHIFT_W - 1)) - wide_t'(1);
  localparam wide_t ShMin   = -(wide_t'(1) <<< (SHIFT_W - 1));

  wide_t dp_q [3][3];
  wide_t ds_q [3];
  logic signed [SHIFT_W-1:0] shift_q [3];
  wide_t tr_r [3];
  wide_t tr_n [3];
  logic signed [SHIFT_W-1:0] shift_d [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tr_r[r] = (ds_q[r] + RndHalf) >>> FRAC_W;
      tr_n[r] = -tr_r[r];
      if (tr_n[r] > ShMax) begin
        shift_d[r] = {1'b0, {(SHIFT_W-1){1'b1}}};
      end else if (tr_n[r] < ShMin) begin
        shift_d[r] = {1'b1, {(SHIFT_W-1){1'b0}}};
      end else begin
        shift_d[r] = tr_n[r][SHIFT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          dp_q[r][i] <= smul(basis[r][i], pos_v[i]);
        end
        ds_q[r]    <= dp_q[r][0] + dp_q[r][1] + dp_q[r][2];
        shift_q[r] <= shift_d[r];
      end
    end
  end

  // basis rides along with the dot products to the output register
  logic [3*VEC3_W-1:0] basis_out;

  lavm_delay #(.WIDTH(3 * VEC3_W), .DEPTH(DOT_LAT)) u_dly_basis (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({w_v_flat, v_q[2], v_q[1], v_q[0], u_v_flat}),
    .q_o   (basis_out)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - 3*VEC3_W - 3*SHIFT_W){1'b0}},
                         shift_q[2], shift_q[1], shift_q[0], basis_out};

endmodule

@@ sv/lavm_checker.sv @@
// Port-level checks for the look-at view matrix block, bound to the top level.
module lavm_checker
  import lavm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic signed [UNIT_W-1:0] OneQ30 = UNIT_W'(1) << FRAC_W;

  logic signed [UNIT_W-1:0] ux, uy, uz, wx, wy, wz;
  logic unit_ok;

  assign ux = $signed(m_axis_tdata[31:0]);
  assign uy = $signed(m_axis_tdata[63:32]);
  assign uz = $signed(m_axis_tdata[95:64]);
  assign wx = $signed(m_axis_tdata[223:192]);
  assign wy = $signed(m_axis_tdata[255:224]);
  assign wz = $signed(m_axis_tdata[287:256]);
  assign unit_ok = (ux <= OneQ30) && (ux >= -OneQ30) && (uy <= OneQ30) && (uy >= -OneQ30)
                && (uz <= OneQ30) && (uz >= -OneQ30) && (wx <= OneQ30) && (wx >= -OneQ30)
                && (wy <= OneQ30) && (wy >= -OneQ30) && (wz <= OneQ30) && (wz >= -OneQ30);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> unit_ok)
    else $error("basis component beyond one");

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (.*);
